// File: sv/s2f_pkg.sv
// Shared constants, types and arithmetic helpers for the stereo upmix filter bank.
`default_nettype none

package s2f_pkg;

   // Field widths.
   localparam int SAMPLE_BITS = 24;
   localparam int HIST_BITS   = 32;
   localparam int PROD_BITS   = 64;

   // Register file map: histories of biquad b sit at 2b, 2b+1 (input side)
   // and 12+2b, 13+2b (output side); the rest hold per-frame values.
   localparam logic [4:0] R_YBASE = 5'd12;
   localparam logic [4:0] R_SL    = 5'd24;
   localparam logic [4:0] R_SR    = 5'd25;
   localparam logic [4:0] R_XL    = 5'd26;
   localparam logic [4:0] R_XR    = 5'd27;
   localparam logic [4:0] R_C     = 5'd28;
   localparam logic [4:0] R_RC    = 5'd29;
   localparam logic [4:0] R_LF    = 5'd30;
   localparam logic [4:0] R_RF    = 5'd31;
   localparam logic [4:0] R_LS    = 5'd12;
   localparam logic [4:0] R_RS    = 5'd18;

   // Coefficient table bases.
   localparam logic [4:0] C_LP11K = 5'd0;
   localparam logic [4:0] C_HP5K  = 5'd5;
   localparam logic [4:0] C_HP3K  = 5'd10;
   localparam logic [4:0] C_M1DB  = 5'd15;
   localparam logic [4:0] C_M10DB = 5'd16;
   localparam logic [4:0] C_M4DB  = 5'd17;
   localparam logic [4:0] C_M9P5  = 5'd18;
   localparam logic [4:0] C_M3P9  = 5'd19;

   // Output modes.
   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_NO_CTR  = 2'd1;
   localparam logic [1:0] MODE_ALL     = 2'd2;

   localparam logic [3:0] LAST_JOB  = 4'd11;
   localparam logic [2:0] LAST_TERM = 3'd4;

   // One job of the frame program: a gain or a full biquad.
   typedef struct packed {
      logic       is_gain;
      logic [4:0] src;
      logic [4:0] cbase;
      logic [2:0] bq;
      logic [4:0] dest;
      logic       add_en;
      logic [4:0] add_src;
   } job_type;

   function automatic job_type job_info(input logic [3:0] job);
      job_type j;
      j = '{is_gain: 1'b1, src: R_XL, cbase: C_M1DB, bq: 3'd0, dest: R_SL,
            add_en: 1'b0, add_src: R_C};
      case (job)
         4'd0:  j = '{1'b1, R_XL,   C_M1DB,  3'd0, R_SL, 1'b0, R_C};
         4'd1:  j = '{1'b1, R_XR,   C_M1DB,  3'd0, R_SR, 1'b0, R_C};
         4'd2:  j = '{1'b0, R_SL,   C_LP11K, 3'd0, R_SL, 1'b0, R_C};
         4'd3:  j = '{1'b0, R_SL,   C_HP5K,  3'd1, R_SL, 1'b0, R_C};
         4'd4:  j = '{1'b1, 5'd14,  C_M10DB, 3'd0, R_C,  1'b0, R_C};
         4'd5:  j = '{1'b0, 5'd12,  C_HP3K,  3'd2, R_SL, 1'b0, R_C};
         4'd6:  j = '{1'b1, 5'd16,  C_M4DB,  3'd0, R_LF, 1'b1, R_C};
         4'd7:  j = '{1'b0, R_SR,   C_LP11K, 3'd3, R_SL, 1'b0, R_C};
         4'd8:  j = '{1'b0, R_SR,   C_HP5K,  3'd4, R_SL, 1'b0, R_C};
         4'd9:  j = '{1'b1, 5'd20,  C_M9P5,  3'd0, R_RC, 1'b0, R_C};
         4'd10: j = '{1'b0, 5'd18,  C_HP3K,  3'd5, R_SL, 1'b0, R_C};
         4'd11: j = '{1'b1, 5'd22,  C_M3P9,  3'd0, R_RF, 1'b1, R_RC};
         default: j = '{1'b1, R_XL, C_M1DB, 3'd0, R_SL, 1'b0, R_C};
      endcase
      return j;
   endfunction

   // Q2.30 coefficients: biquads as b0, b1, b2, a1, a2, then the gains.
   function automatic logic signed [31:0] coef_of(input logic [4:0] idx);
      logic signed [31:0] c;
      c = 32'sd0;
      case (idx)
         5'd0:  c = 32'sd295478837;
         5'd1:  c = 32'sd590957674;
         5'd2:  c = 32'sd295478837;
         5'd3:  c = -32'sd177430198;
         5'd4:  c = 32'sd285603721;
         5'd5:  c = 32'sd710028503;
         5'd6:  c = -32'sd1420057006;
         5'd7:  c = 32'sd710028503;
         5'd8:  c = -32'sd1256424982;
         5'd9:  c = 32'sd509947206;
         5'd10: c = 32'sd843995873;
         5'd11: c = -32'sd1687991746;
         5'd12: c = 32'sd843995873;
         5'd13: c = -32'sd1621204445;
         5'd14: c = 32'sd681037223;
         5'd15: c = 32'sd956973474;
         5'd16: c = 32'sd339547230;
         5'd17: c = 32'sd677484920;
         5'd18: c = 32'sd359665930;
         5'd19: c = 32'sd685329678;
         default: c = 32'sd0;
      endcase
      return c;
   endfunction

   // Saturate a 40-bit value to 32 bits.
   function automatic logic [31:0] sat32(input logic signed [39:0] v);
      logic [31:0] r;
      if (v > 40'sh007FFFFFFF) begin
         r = 32'h7FFFFFFF;
      end else if (v < -40'sh0080000000) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Saturate a 32-bit value to the sample width.
   function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [31:0] v);
      logic [SAMPLE_BITS-1:0] r;
      if (v > 32'sh007FFFFF) begin
         r = 24'h7FFFFF;
      end else if (v < -32'sh00800000) begin
         r = 24'h800000;
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/stereo_to_five_channel_upmix.sv
// Top level of the stereo to five-channel upmix filter bank.
// One stereo word in gives one five-channel word out. A frame runs as a fixed
// program of twelve jobs (two input gains, six direct-form-I biquads, four
// output gains) on one Booth serial multiplier; 36 products (each a load, a
// multiply wait and an accumulate) plus twelve finishing and six history steps
// and the output load make up a frame from accepting a word to its result, and a
// new word is taken once the result has moved into the output register, which
// holds it until taken.
// The mode register is written through its own port and takes effect on the
// next result; the filter histories advance in every mode.
`default_nettype none

module stereo_to_five_channel_upmix (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [s2f_pkg::SAMPLE_BITS-1:0] req_in_left,
   input  wire logic [s2f_pkg::SAMPLE_BITS-1:0] req_in_right,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [s2f_pkg::SAMPLE_BITS-1:0]      rsp_out_left,
   output logic [s2f_pkg::SAMPLE_BITS-1:0]      rsp_out_right,
   output logic [s2f_pkg::SAMPLE_BITS-1:0]      rsp_out_left_surround,
   output logic [s2f_pkg::SAMPLE_BITS-1:0]      rsp_out_right_surround,
   output logic [s2f_pkg::SAMPLE_BITS-1:0]      rsp_out_centre,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [1:0]                      csr_output_mode
);
   import s2f_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOAD = 7'b0000010,
      S_MUL  = 7'b0000100,
      S_ACC  = 7'b0001000,
      S_FIN  = 7'b0010000,
      S_UPD  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         job_ff, job_in;
   logic [2:0]         term_ff, term_in;
   logic [63:0]        acc_ff, acc_in;
   logic [31:0]        y_ff, y_in;
   logic [31:0]        rf_ff [32];
   logic [1:0]         mode_ff;
   logic               rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] out_l_ff, out_r_ff, out_ls_ff, out_rs_ff, out_c_ff;

   job_type            job;
   logic [4:0]         bq_k;
   logic [4:0]         op_addr;
   logic [4:0]         rd_addr;
   logic [31:0]        rd_data;
   logic signed [31:0] coef;
   logic               mul_done;
   logic [63:0]        mul_product;
   logic signed [63:0] term_val;
   logic signed [63:0] bq_round;
   logic signed [63:0] g_round;
   logic signed [39:0] g_sum;
   logic [31:0]        bq_y;
   logic [31:0]        g_val;
   logic               accept;
   logic               rsp_load;
   logic               last_job;

   assign job      = job_info(job_ff);
   assign bq_k     = {1'b0, job.bq, 1'b0};
   assign accept   = req_valid && (state_ff == S_IDLE);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign last_job = (job_ff == LAST_JOB);

   // Operand address for the current term of the job.
   always_comb begin
      case (term_ff)
         3'd0:    op_addr = job.src;
         3'd1:    op_addr = bq_k;
         3'd2:    op_addr = bq_k | 5'd1;
         3'd3:    op_addr = bq_k + R_YBASE;
         3'd4:    op_addr = bq_k + R_YBASE + 5'd1;
         default: op_addr = job.src;
      endcase
   end

   // Single read port: operand on load, addend on finish, filter input on update.
   always_comb begin
      case (state_ff)
         S_LOAD:  rd_addr = op_addr;
         S_FIN:   rd_addr = job.add_src;
         default: rd_addr = job.src;
      endcase
   end
   assign rd_data = rf_ff[rd_addr];
   assign coef    = coef_of(job.cbase + {2'b00, term_ff});

   s2f_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_LOAD),
      .mcand   (rd_data),
      .mplier  (coef),
      .done    (mul_done),
      .product (mul_product)
   );

   // Rounding and saturation of finished sums.
   assign term_val = $signed(mul_product) >>> 2;
   assign bq_round = ($signed(acc_ff) + 64'sd134217728) >>> 28;
   assign bq_y     = sat32(bq_round[39:0]);
   assign g_round  = ($signed(acc_ff) + 64'sd536870912) >>> 30;
   assign g_sum    = g_round[39:0] +
                     (job.add_en ? {{8{rd_data[31]}}, rd_data} : 40'sd0);
   assign g_val    = sat32(g_sum);

   // Job sequencer.
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      term_in  = term_ff;
      acc_in   = acc_ff;
      y_in     = y_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
               job_in   = 4'd0;
               term_in  = 3'd0;
            end
         end
         S_LOAD: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mul_done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (job.is_gain) begin
               acc_in = mul_product;
            end else if (term_ff >= 3'd3) begin
               acc_in = acc_ff - term_val;
            end else if (term_ff == 3'd0) begin
               acc_in = term_val;
            end else begin
               acc_in = acc_ff + term_val;
            end
            if (job.is_gain || (term_ff == LAST_TERM)) begin
               state_in = S_FIN;
            end else begin
               term_in  = term_ff + 3'd1;
               state_in = S_LOAD;
            end
         end
         S_FIN: begin
            if (job.is_gain) begin
               term_in  = 3'd0;
               job_in   = last_job ? job_ff : job_ff + 4'd1;
               state_in = last_job ? S_DONE : S_LOAD;
            end else begin
               y_in     = bq_y;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            term_in  = 3'd0;
            job_in   = last_job ? job_ff : job_ff + 4'd1;
            state_in = last_job ? S_DONE : S_LOAD;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff   <= 4'd0;
         term_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         term_ff  <= term_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      y_ff   <= y_in;
   end

   // Register file: histories, inputs and intermediate results.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) begin
            rf_ff[i] <= 32'd0;
         end
      end else if (accept) begin
         rf_ff[R_XL] <= {{8{req_in_left[SAMPLE_BITS-1]}}, req_in_left};
         rf_ff[R_XR] <= {{8{req_in_right[SAMPLE_BITS-1]}}, req_in_right};
      end else if ((state_ff == S_FIN) && job.is_gain) begin
         rf_ff[job.dest] <= g_val;
      end else if (state_ff == S_UPD) begin
         rf_ff[bq_k | 5'd1]             <= rf_ff[bq_k];
         rf_ff[bq_k]                    <= rd_data;
         rf_ff[bq_k + R_YBASE + 5'd1]   <= rf_ff[bq_k + R_YBASE];
         rf_ff[bq_k + R_YBASE]          <= y_ff;
      end
   end

   // Mode register; the port is always ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ALL;
      end else if (csr_valid) begin
         mode_ff <= csr_output_mode;
      end
   end
   assign csr_ready = 1'b1;

   // Output register holds the word until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_l_ff  <= sat_sample(rf_ff[R_LF]);
         out_r_ff  <= sat_sample(rf_ff[R_RF]);
         out_ls_ff <= (mode_ff == MODE_NONE) ? '0 : sat_sample(rf_ff[R_LS]);
         out_rs_ff <= (mode_ff == MODE_NONE) ? '0 : sat_sample(rf_ff[R_RS]);
         out_c_ff  <= ((mode_ff == MODE_NONE) || (mode_ff == MODE_NO_CTR)) ?
                      '0 : sat_sample(rf_ff[R_C]);
      end
   end

   assign req_stall              = (state_ff != S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_out_left           = out_l_ff;
   assign rsp_out_right          = out_r_ff;
   assign rsp_out_left_surround  = out_ls_ff;
   assign rsp_out_right_surround = out_rs_ff;
   assign rsp_out_centre         = out_c_ff;

   // The multiplier only reports a product while the sequencer waits for it.
   a_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL))
      else $error("product finished outside the multiply wait");

   // Term index never runs past the last biquad term.
   a_term_range: assert property (@(posedge clock) disable iff (reset)
      term_ff <= LAST_TERM)
      else $error("term index out of range");

   // A new frame starts only from the first job.
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((job_ff == 4'd0) && (term_ff == 3'd0) && (state_ff == S_LOAD)))
      else $error("frame did not start at the first job");

   // The sequencer reaches the output stage only after the last job.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_DONE) |-> (job_ff == LAST_JOB))
      else $error("frame finished before the last job");

endmodule

`default_nettype wire

// File: sv/s2f_mul.sv
// Radix-2 Booth serial multiplier, one multiplier bit per cycle.
`default_nettype none

module s2f_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] mcand,
   input  wire logic [31:0] mplier,
   output logic             done,
   output logic [63:0]      product
);
   import s2f_pkg::*;

   logic        busy_ff;
   logic [4:0]  cnt_ff;
   logic [64:0] prod_ff;
   logic        qm1_ff;
   logic [32:0] mcand_ff;
   logic        done_ff;
   logic [32:0] sum_in;

   // Booth recoding of the current bit pair picks add, subtract or hold.
   always_comb begin
      case ({prod_ff[0], qm1_ff})
         2'b01:   sum_in = prod_ff[64:32] + mcand_ff;
         2'b10:   sum_in = prod_ff[64:32] - mcand_ff;
         default: sum_in = prod_ff[64:32];
      endcase
   end

   // Control: count 32 steps, then flag the product for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 5'd31);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath: add into the upper half, then arithmetic shift right.
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= {mcand[31], mcand};
         prod_ff  <= {33'd0, mplier};
         qm1_ff   <= 1'b0;
      end else if (busy_ff) begin
         prod_ff <= {sum_in[32], sum_in, prod_ff[31:1]};
         qm1_ff  <= prod_ff[0];
      end
   end

   assign done    = done_ff;
   assign product = prod_ff[PROD_BITS-1:0];

endmodule

`default_nettype wire
